FILE: rtl/kmwm_pkg.sv
// ----------------------------------------------------------------------------
// kmwm_pkg: shared definitions for the k-mismatch window matcher
// Field widths, item codes, register indexes, state encoding and the control
// word handed from the sequencer to the row of cells.
// ----------------------------------------------------------------------------
package kmwm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 64;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned PIDX_W     = 6;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned DIST_OUT_W = 6;
  localparam int unsigned DIST_SAT   = (1 << DIST_OUT_W) - 1;

  localparam logic [CFG_DATA_W-1:0] PATTERN_LENGTH_RST = 7'd8;
  localparam logic [CFG_DATA_W-1:0] MISMATCH_LIMIT_RST = 7'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_PUSH    = 2'd1,
    ACT_RESTART = 2'd2
  } action_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_MISMATCH_LIMIT = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_e;

  // Control word broadcast to every cell of the row.
  typedef struct packed {
    logic push;   // shift a new text byte into the history row
    logic copy;   // snapshot history and pattern into the working rows
    logic shift;  // advance the working rows by one cell
  } cell_ctrl_t;

endpackage

FILE: rtl/kmwm_if.sv
// ----------------------------------------------------------------------------
// kmwm channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface kmwm_item_if;
  logic                               valid;
  logic                               ready;
  logic [kmwm_pkg::ACTION_W-1:0]      action;
  logic [kmwm_pkg::PIDX_W-1:0]        pattern_index;
  logic [kmwm_pkg::CHAR_W-1:0]        char_value;

  modport source (output valid, output action, output pattern_index, output char_value,
                  input ready);
  modport sink   (input valid, input action, input pattern_index, input char_value,
                  output ready);
endinterface

interface kmwm_result_if;
  logic                               valid;
  logic                               ready;
  logic [kmwm_pkg::POS_W-1:0]         window_start;
  logic                               matched;
  logic [kmwm_pkg::DIST_OUT_W-1:0]    mismatch_count;

  modport source (output valid, output window_start, output matched,
                  output mismatch_count, input ready);
  modport sink   (input valid, input window_start, input matched,
                  input mismatch_count, output ready);
endinterface

interface kmwm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [kmwm_pkg::CFG_ADDR_W-1:0]    index;
  logic [kmwm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/kmwm_cell.sv
// ----------------------------------------------------------------------------
// kmwm_cell: one position of the matcher row
// Holds one pattern byte, one history byte and one byte of each working row,
// and passes history and working bytes to its neighbors.
// ----------------------------------------------------------------------------
module kmwm_cell (
  input  logic                        clk_i,
  input  kmwm_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        pat_we_i,
  input  logic [kmwm_pkg::CHAR_W-1:0] char_i,
  input  logic [kmwm_pkg::CHAR_W-1:0] h_prev_i,
  input  logic [kmwm_pkg::CHAR_W-1:0] w_prev_i,
  input  logic [kmwm_pkg::CHAR_W-1:0] q_next_i,
  output logic [kmwm_pkg::CHAR_W-1:0] h_o,
  output logic [kmwm_pkg::CHAR_W-1:0] w_o,
  output logic [kmwm_pkg::CHAR_W-1:0] q_o
);

  logic [kmwm_pkg::CHAR_W-1:0] p_q, p_d;
  logic [kmwm_pkg::CHAR_W-1:0] h_q, h_d;
  logic [kmwm_pkg::CHAR_W-1:0] w_q, w_d;
  logic [kmwm_pkg::CHAR_W-1:0] q_q, q_d;

  always_comb begin
    p_d = pat_we_i    ? char_i   : p_q;
    h_d = ctrl_i.push ? h_prev_i : h_q;
    // The snapshot takes the history as it stands after the push.
    if (ctrl_i.copy) begin
      w_d = h_prev_i;
      q_d = p_q;
    end else if (ctrl_i.shift) begin
      w_d = w_prev_i;
      q_d = q_next_i;
    end else begin
      w_d = w_q;
      q_d = q_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    h_q <= h_d;
    w_q <= w_d;
    q_q <= q_d;
  end

  assign h_o = h_q;
  assign w_o = w_q;
  assign q_o = q_q;

endmodule

FILE: rtl/kmwm_ctrl.sv
// ----------------------------------------------------------------------------
// kmwm_ctrl: sequencer, registers and result stage
// Takes items and register writes, steps the working rows through one window
// comparison, counts mismatches and holds the result word.
// ----------------------------------------------------------------------------
module kmwm_ctrl #(
  parameter  int unsigned PATTERN_MAX = kmwm_pkg::PATTERN_MAX_DEF,
  localparam int unsigned IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kmwm_item_if.sink                   item_i,
  kmwm_result_if.source               result_o,
  kmwm_cfg_if.sink                    cfg_i,
  input  logic [kmwm_pkg::CHAR_W-1:0] tap_char_i,
  input  logic [kmwm_pkg::CHAR_W-1:0] head_pat_i,
  output logic [IW-1:0]               tap_idx_o,
  output logic                        load_en_o,
  output kmwm_pkg::cell_ctrl_t        cell_ctrl_o
);

  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CW = (LW > kmwm_pkg::CFG_DATA_W) ? LW : kmwm_pkg::CFG_DATA_W;
  localparam int unsigned DW = LW;
  localparam int unsigned MW = (DW > kmwm_pkg::CFG_DATA_W) ? DW : kmwm_pkg::CFG_DATA_W;

  kmwm_pkg::state_e                 state_q, state_d;
  logic [kmwm_pkg::CFG_DATA_W-1:0]  len_cfg_q, lim_q;
  logic [kmwm_pkg::POS_W-1:0]       count_q, count_d;
  logic [IW-1:0]                    rem_q, rem_d;
  logic [DW-1:0]                    acc_q, acc_d;
  logic                             out_valid_q, out_valid_d;
  logic [kmwm_pkg::POS_W-1:0]       out_start_q;
  logic                             out_matched_q;
  logic [kmwm_pkg::DIST_OUT_W-1:0]  out_count_q;

  logic [CW-1:0]                    len_cfg_ext, len_eff, len_m1;
  logic                             item_ready, item_acc, is_push, is_restart;
  logic                             mism, out_load, res_matched;
  logic [MW-1:0]                    dist_ext;
  logic [kmwm_pkg::DIST_OUT_W-1:0]  res_count;

  // Window length, clamped to the range 1 to the row length.
  always_comb begin
    len_cfg_ext = CW'(len_cfg_q);
    if (len_cfg_ext == '0) begin
      len_eff = CW'(1);
    end else if (len_cfg_ext > CW'(PATTERN_MAX)) begin
      len_eff = CW'(PATTERN_MAX);
    end else begin
      len_eff = len_cfg_ext;
    end
    len_m1 = len_eff - CW'(1);
  end

  assign tap_idx_o  = len_m1[IW-1:0];
  assign item_ready = (state_q == kmwm_pkg::ST_IDLE);
  assign item_i.ready = item_ready;
  assign item_acc   = item_i.valid & item_ready;
  assign is_push    = item_acc & (item_i.action == kmwm_pkg::ACT_PUSH);
  assign is_restart = item_acc & (item_i.action == kmwm_pkg::ACT_RESTART);
  assign load_en_o  = item_acc & (item_i.action == kmwm_pkg::ACT_LOAD);
  assign mism       = (tap_char_i != head_pat_i);

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    count_d     = count_q;
    cell_ctrl_o = '0;
    out_load    = 1'b0;
    unique case (state_q)
      kmwm_pkg::ST_IDLE: begin
        if (is_restart) begin
          count_d = '0;
        end else if (is_push) begin
          cell_ctrl_o.push = 1'b1;
          if (count_q != '1) begin
            count_d = count_q + kmwm_pkg::POS_W'(1);
          end
          if (count_d >= kmwm_pkg::POS_W'(len_eff)) begin
            cell_ctrl_o.copy = 1'b1;
            rem_d   = len_m1[IW-1:0];
            acc_d   = '0;
            state_d = kmwm_pkg::ST_RUN;
          end
        end
      end
      kmwm_pkg::ST_RUN: begin
        // One pattern position per cycle meets its text byte at the tap.
        cell_ctrl_o.shift = 1'b1;
        acc_d = acc_q + DW'(mism);
        if (rem_q == '0) begin
          state_d = kmwm_pkg::ST_EMIT;
        end else begin
          rem_d = rem_q - IW'(1);
        end
      end
      kmwm_pkg::ST_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = kmwm_pkg::ST_IDLE;
        end
      end
      default: state_d = kmwm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    dist_ext    = MW'(acc_q);
    res_matched = dist_ext < MW'(lim_q);
    if (!res_matched) begin
      res_count = '0;
    end else if (dist_ext > MW'(kmwm_pkg::DIST_SAT)) begin
      res_count = kmwm_pkg::DIST_OUT_W'(kmwm_pkg::DIST_SAT);
    end else begin
      res_count = dist_ext[kmwm_pkg::DIST_OUT_W-1:0];
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kmwm_pkg::ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      len_cfg_q   <= kmwm_pkg::PATTERN_LENGTH_RST;
      lim_q       <= kmwm_pkg::MISMATCH_LIMIT_RST;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          kmwm_pkg::REG_PATTERN_LENGTH: len_cfg_q <= cfg_i.data;
          kmwm_pkg::REG_MISMATCH_LIMIT: lim_q     <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_start_q   <= count_q - kmwm_pkg::POS_W'(len_eff);
      out_matched_q <= res_matched;
      out_count_q   <= res_count;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.window_start   = out_start_q;
  assign result_o.matched        = out_matched_q;
  assign result_o.mismatch_count = out_count_q;

  a_run_ends_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmwm_pkg::ST_RUN && rem_q == '0) |=> (state_q == kmwm_pkg::ST_EMIT))
    else $error("comparison pass did not end in the hand-off step");

  a_acc_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmwm_pkg::ST_EMIT) |-> (acc_q <= DW'(PATTERN_MAX)))
    else $error("mismatch count exceeds the row length");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmwm_pkg::ST_EMIT && out_valid_q && !result_o.ready)
      |=> (state_q == kmwm_pkg::ST_EMIT && out_valid_q))
    else $error("result overwrote a word still waiting at the output");

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_matched_q) |-> (out_count_q == '0))
    else $error("no-match word carries a nonzero mismatch count");

endmodule

FILE: rtl/k_mismatch_window_matcher_top.sv
// ----------------------------------------------------------------------------
// k_mismatch_window_matcher_top: Hamming-distance window matcher
// Compares a loaded pattern against every window of a text byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries words that load a pattern byte, push a text byte or restart
//   the text stream. result_o returns one word per pushed byte once a full
//   window is present: the window start, a match flag and the mismatch count.
//   cfg_i writes the window length and the mismatch limit; it is always ready
//   and should only be written while the block is idle.
// Sequence:
//   Load, restart and pushes that do not complete a window are done on accept.
//   A push that completes a window then runs, L being the window length: one
//   accept step, L compare steps while the working rows shift one cell per
//   cycle past a single compare tap, and one hand-off step. Items wait meanwhile.
//   The result is visible on result_o the cycle after the hand-off.
// Reset:
//   The position counter clears and the registers take their reset values.
//   Pattern bytes are undefined until loaded.
// Back-pressure:
//   A result waits in the output register while the next item is taken; a
//   further result stays in the hand-off step until that register is free.
// ----------------------------------------------------------------------------
module k_mismatch_window_matcher_top #(
  parameter int unsigned PATTERN_MAX = kmwm_pkg::PATTERN_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  kmwm_item_if.sink      item_i,
  kmwm_result_if.source  result_o,
  kmwm_cfg_if.sink       cfg_i
);

  localparam int unsigned IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [kmwm_pkg::CHAR_W-1:0] h_row [PATTERN_MAX];
  logic [kmwm_pkg::CHAR_W-1:0] w_row [PATTERN_MAX];
  logic [kmwm_pkg::CHAR_W-1:0] q_row [PATTERN_MAX];
  logic [IW-1:0]               tap_idx;
  logic                        load_en;
  kmwm_pkg::cell_ctrl_t        cell_ctrl;
  logic [kmwm_pkg::CHAR_W-1:0] tap_char;

  assign tap_char = w_row[tap_idx];

  kmwm_ctrl #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .result_o    (result_o),
    .cfg_i       (cfg_i),
    .tap_char_i  (tap_char),
    .head_pat_i  (q_row[0]),
    .tap_idx_o   (tap_idx),
    .load_en_o   (load_en),
    .cell_ctrl_o (cell_ctrl)
  );

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [kmwm_pkg::CHAR_W-1:0] h_prev, w_prev, q_next;
    logic                        pat_we;

    // History enters at cell 0; the text working row moves up, the pattern
    // working row moves down toward the tap at cell 0.
    if (i == 0) begin : g_head
      assign h_prev = item_i.char_value;
      assign w_prev = '0;
    end else begin : g_body
      assign h_prev = h_row[i-1];
      assign w_prev = w_row[i-1];
    end

    if (i == PATTERN_MAX - 1) begin : g_tail
      assign q_next = '0;
    end else begin : g_link
      assign q_next = q_row[i+1];
    end

    assign pat_we = load_en & (32'(item_i.pattern_index) == 32'(i));

    kmwm_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .pat_we_i (pat_we),
      .char_i   (item_i.char_value),
      .h_prev_i (h_prev),
      .w_prev_i (w_prev),
      .q_next_i (q_next),
      .h_o      (h_row[i]),
      .w_o      (w_row[i]),
      .q_o      (q_row[i])
    );
  end

endmodule
